@@ rtl/htbd_pkg.sv @@
// Package: shared types and constants for the huffman tree bit decoder.
`default_nettype none
package htbd_pkg;
   localparam int MAX_NODES = 511;
   localparam int STACK_DEPTH = 256;
   localparam int MAX_FILES = 16;
   localparam int NODE_W = $clog2(MAX_NODES);
   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int STK_AW = $clog2(STACK_DEPTH);
   localparam int QA_W = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
   localparam int QC_W = $clog2(MAX_FILES + 1);
   localparam logic [7:0] CODE_INTERNAL = 8'h30;
   localparam logic [7:0] CODE_LEAF = 8'h31;
   localparam logic [1:0] KIND_TREE = 2'd0;
   localparam logic [1:0] KIND_COUNT = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;
   localparam logic [1:0] KIND_EOS = 2'd3;
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BAD_CODE = 3'd1;
   localparam logic [2:0] ST_MISUSE = 3'd2;
   localparam logic [2:0] ST_QFULL = 3'd3;
   localparam logic [2:0] ST_INCOMPLETE = 3'd4;
   localparam int CMD_DEPTH = 2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  node_code;
      logic [7:0]  leaf_symbol;
      logic [31:0] file_length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic        out_kind;
      logic [7:0]  symbol;
      logic [15:0] file_index;
      logic        file_end;
      logic [2:0]  status;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

@@ rtl/htbd_if.sv @@
// Interfaces: valid/ready channels for requests and responses.
`default_nettype none
interface htbd_req_if import htbd_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface htbd_rsp_if import htbd_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/htbd_cmd_fifo.sv @@
// Short command queue between the front and back parts.
`default_nettype none
module htbd_cmd_fifo import htbd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  req_type      push_data,
   output logic         full,
   input  wire logic    pop,
   output req_type      pop_data,
   output logic         empty
);
   req_type mem_ff [CMD_DEPTH];
   logic [$clog2(CMD_DEPTH)-1:0] wp_ff, rp_ff;
   logic [$clog2(CMD_DEPTH+1)-1:0] cnt_ff;

   assign full = (cnt_ff == ($clog2(CMD_DEPTH+1))'(CMD_DEPTH));
   assign empty = (cnt_ff == '0);
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wp_ff] <= push_data;
      end
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) wp_ff <= wp_ff + 1'b1;
         if (pop && !empty) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + ($clog2(CMD_DEPTH+1))'(push && !full)
                   - ($clog2(CMD_DEPTH+1))'(pop && !empty);
      end
   end
endmodule
`default_nettype wire

@@ rtl/htbd_engine.sv @@
// Back part: tree build, length queue and bit-serial tree walk.
`default_nettype none
module htbd_engine import htbd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  req_type      cmd,
   output logic         cmd_pop,
   htbd_rsp_if.source   rsp
);
   typedef enum logic [3:0] {
      S_IDLE, S_TREE_RD, S_TREE_WR, S_SKIP, S_BIT_RD, S_BIT_WAIT, S_BIT_EVAL,
      S_DATA_END, S_EMIT, S_EOS
   } state_type;

   state_type state_ff;
   req_type cur_ff;
   logic [26:0] node_mem [MAX_NODES];
   logic [9:0]  stack_mem [STACK_DEPTH];
   logic [31:0] queue_mem [MAX_FILES];
   logic [SP_W-1:0] sp_ff;
   logic [NODE_W:0] ncount_ff;
   logic tree_done_ff;
   logic [NODE_W-1:0] walk_ff;
   logic [QA_W-1:0] head_ff;
   logic [QC_W-1:0] qcount_ff;
   logic [31:0] syms_ff;
   logic [15:0] file_ff;
   logic [26:0] nrd_ff;
   logic [9:0] top_ff;
   logic [2:0] bit_ff;
   logic any_ff;
   logic [2:0] next_st_ff;
   rsp_type out_ff;
   logic out_valid_ff;
   rsp_type pend_ff;
   logic pend_v_ff;

   logic [QA_W-1:0] tail;
   logic [QA_W-1:0] head_inc;
   logic [31:0] head_len;
   logic pend, is_leaf;
   logic [SP_W-1:0] newsp;
   logic [NODE_W-1:0] nx;
   logic data_bit;
   logic can_out;

   always_comb begin
      if (MAX_FILES == 1) begin
         tail = '0;
         head_inc = '0;
      end else begin
         tail = QA_W'((32'(head_ff) + 32'(qcount_ff)) % MAX_FILES);
         head_inc = QA_W'((32'(head_ff) + 32'd1) % MAX_FILES);
      end
   end
   assign head_len = queue_mem[head_ff];
   assign pend = (sp_ff != '0) && top_ff[9];
   assign newsp = sp_ff - SP_W'(pend);
   assign is_leaf = (cur_ff.node_code == CODE_LEAF);
   assign data_bit = cur_ff.data_byte[bit_ff];
   always_comb begin
      nx = data_bit ? nrd_ff[NODE_W-1:0] : nrd_ff[9+:NODE_W];
      if (32'(nx) >= MAX_NODES) nx = '0;
   end
   assign can_out = !out_valid_ff || rsp.ready;
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;
   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid && !pend_v_ff && can_out;

   function automatic rsp_type mk_status(logic [2:0] st, logic [15:0] f);
      rsp_type r;
      r = '0;
      r.out_kind = 1'b1;
      r.file_index = f;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      nrd_ff <= node_mem[walk_ff];
      if (state_ff == S_IDLE && cmd_pop) begin
         cur_ff <= cmd;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff <= '0;
         ncount_ff <= '0;
         tree_done_ff <= 1'b0;
         walk_ff <= '0;
         head_ff <= '0;
         qcount_ff <= '0;
         syms_ff <= '0;
         file_ff <= '0;
         out_valid_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         bit_ff <= 3'd7;
         any_ff <= 1'b0;
         next_st_ff <= '0;
      end else begin
         if (out_valid_ff && rsp.ready) out_valid_ff <= 1'b0;
         if (pend_v_ff && can_out) begin
            out_ff <= pend_ff;
            out_valid_ff <= 1'b1;
            pend_v_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_pop) begin
                  unique case (cmd.kind)
                     KIND_TREE: begin
                        if (tree_done_ff) begin
                           out_ff <= mk_status(ST_MISUSE, file_ff);
                           out_valid_ff <= 1'b1;
                        end else if (cmd.node_code != CODE_INTERNAL &&
                                     cmd.node_code != CODE_LEAF) begin
                           out_ff <= mk_status(ST_BAD_CODE, file_ff);
                           out_valid_ff <= 1'b1;
                        end else if (32'(ncount_ff) >= MAX_NODES) begin
                           out_ff <= mk_status(ST_MISUSE, file_ff);
                           out_valid_ff <= 1'b1;
                        end else begin
                           top_ff <= stack_mem[STK_AW'(sp_ff - 1'b1)];
                           state_ff <= S_TREE_RD;
                        end
                     end
                     KIND_COUNT: begin
                        if (32'(qcount_ff) >= MAX_FILES) begin
                           out_ff <= mk_status(ST_QFULL, file_ff);
                           out_valid_ff <= 1'b1;
                        end else begin
                           queue_mem[tail] <= cmd.file_length;
                           qcount_ff <= qcount_ff + 1'b1;
                           next_st_ff <= 3'd0;
                           state_ff <= S_SKIP;
                        end
                     end
                     KIND_DATA: begin
                        if (!tree_done_ff) begin
                           out_ff <= mk_status(ST_MISUSE, file_ff);
                           out_valid_ff <= 1'b1;
                        end else begin
                           bit_ff <= 3'd7;
                           any_ff <= 1'b0;
                           next_st_ff <= 3'd1;
                           state_ff <= S_SKIP;
                        end
                     end
                     default: begin
                        next_st_ff <= 3'd2;
                        state_ff <= S_SKIP;
                     end
                  endcase
               end
            end
            S_TREE_RD: begin
               state_ff <= S_TREE_WR;
               if (!is_leaf && 32'(newsp) >= STACK_DEPTH) begin
                  pend_ff <= mk_status(ST_MISUSE, file_ff);
                  pend_v_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_TREE_WR: begin
               state_ff <= S_IDLE;
               // Parent link: node_mem written via read-modify in walk read path
               node_mem[NODE_W'(ncount_ff)] <= is_leaf ?
                  {1'b1, cur_ff.leaf_symbol, 18'd0} : 27'd0;
               sp_ff <= newsp;
               ncount_ff <= ncount_ff + 1'b1;
               if (!is_leaf) begin
                  stack_mem[STK_AW'(newsp)] <= {1'b0, 9'(ncount_ff)};
                  sp_ff <= newsp + 1'b1;
               end else if (newsp == '0) begin
                  if (ncount_ff == '0) begin
                     ncount_ff <= '0;
                     pend_ff <= mk_status(ST_MISUSE, file_ff);
                     pend_v_ff <= 1'b1;
                  end else begin
                     tree_done_ff <= 1'b1;
                     walk_ff <= '0;
                  end
               end
               if (sp_ff != '0 && 32'(top_ff[8:0]) < MAX_NODES) begin
                  if (!pend) begin
                     stack_mem[STK_AW'(sp_ff - 1'b1)] <= {1'b1, top_ff[8:0]};
                  end
                  walk_ff <= NODE_W'(top_ff[8:0]);
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               // parent patch: the parent entry is read into nrd_ff here and merged in S_EOS
               state_ff <= S_EOS;
            end
            S_EOS: begin
               if (top_ff[9]) begin
                  node_mem[walk_ff] <= nrd_ff | 27'(NODE_W'(ncount_ff - 1'b1));
               end else begin
                  node_mem[walk_ff] <= nrd_ff |
                     (27'(NODE_W'(ncount_ff - 1'b1)) << 9);
               end
               walk_ff <= '0;
               state_ff <= S_IDLE;
            end
            S_SKIP: begin
               if (qcount_ff != '0 && head_len == 32'd0) begin
                  head_ff <= head_inc;
                  qcount_ff <= qcount_ff - 1'b1;
                  file_ff <= file_ff + 1'b1;
               end else if (next_st_ff == 3'd0) begin
                  state_ff <= S_IDLE;
               end else if (next_st_ff == 3'd2) begin
                  if (can_out && !pend_v_ff) begin
                     out_ff <= mk_status((qcount_ff != '0) ? ST_INCOMPLETE : ST_OK,
                                         file_ff);
                     out_valid_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end else if (next_st_ff == 3'd3) begin
                  state_ff <= S_BIT_RD;
               end else begin
                  state_ff <= (qcount_ff != '0) ? S_BIT_RD : S_DATA_END;
               end
            end
            S_BIT_RD: begin
               walk_ff <= nx;
               state_ff <= S_BIT_WAIT;
            end
            S_BIT_WAIT: begin
               state_ff <= S_BIT_EVAL;
            end
            S_BIT_EVAL: begin
               if (nrd_ff[26]) begin
                  if (!pend_v_ff && can_out) begin
                     if (any_ff) begin
                        out_ff <= pend_ff;
                        out_valid_ff <= 1'b1;
                     end
                     pend_ff.out_kind <= 1'b0;
                     pend_ff.symbol <= nrd_ff[25:18];
                     pend_ff.file_index <= file_ff;
                     pend_ff.file_end <= (syms_ff + 1'b1 == head_len);
                     pend_ff.status <= ST_OK;
                     pend_ff.last <= 1'b0;
                     any_ff <= 1'b1;
                     walk_ff <= '0;
                     if (syms_ff + 1'b1 == head_len) begin
                        syms_ff <= '0;
                        head_ff <= head_inc;
                        qcount_ff <= qcount_ff - 1'b1;
                        file_ff <= file_ff + 1'b1;
                     end else begin
                        syms_ff <= syms_ff + 1'b1;
                     end
                     if (bit_ff == 3'd0) begin
                        state_ff <= S_DATA_END;
                        next_st_ff <= 3'd4;
                     end else begin
                        bit_ff <= bit_ff - 1'b1;
                        next_st_ff <= 3'd1;
                        state_ff <= S_SKIP;
                     end
                  end
               end else if (bit_ff == 3'd0) begin
                  state_ff <= S_DATA_END;
                  next_st_ff <= 3'd4;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
                  state_ff <= S_BIT_RD;
               end
            end
            S_DATA_END: begin
               if (next_st_ff == 3'd4) begin
                  next_st_ff <= 3'd5;
                  if (qcount_ff != '0 && head_len == 32'd0) begin
                     head_ff <= head_inc;
                     qcount_ff <= qcount_ff - 1'b1;
                     file_ff <= file_ff + 1'b1;
                     next_st_ff <= 3'd4;
                  end
               end else if (!pend_v_ff && can_out) begin
                  if (qcount_ff == '0) walk_ff <= '0;
                  if (any_ff) begin
                     out_ff <= pend_ff;
                     out_ff.last <= 1'b1;
                     out_valid_ff <= 1'b1;
                  end
                  any_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ rtl/htbd_front.sv @@
// Front part: accepts request transactions into the command queue.
`default_nettype none
module htbd_front import htbd_pkg::*; (
   htbd_req_if.sink    req,
   input  wire logic   full,
   output logic        push,
   output req_type     push_data
);
   assign req.ready = !full;
   assign push = req.valid && !full;
   always_comb begin
      push_data = req.data;
      unique case (req.data.kind)
         KIND_TREE, KIND_COUNT, KIND_DATA, KIND_EOS: push_data.kind = req.data.kind;
         default: push_data.kind = KIND_EOS;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/huffman_tree_bit_decoder.sv @@
// Top level: huffman decoder with preorder tree loading.
// Results are registered. The engine takes one request from the command queue at a time.
// Tree tokens pass read and write states, plus emit and patch states for a parent link;
// counts also skip each zero-length file at the queue head. Data bytes walk the tree
// bit by bit, with a skip step after each leaf; output stalls hold the engine.
// Reset is synchronous, active high; tables need no clearing.
`default_nettype none
module huffman_tree_bit_decoder import htbd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   htbd_req_if.sink   req,
   htbd_rsp_if.source rsp
);
   logic full, push, empty, pop;
   req_type push_data, pop_data;

   htbd_front u_front (.req(req), .full(full), .push(push), .push_data(push_data));
   htbd_cmd_fifo u_fifo (.clock(clock), .reset(reset), .push(push),
      .push_data(push_data), .full(full), .pop(pop), .pop_data(pop_data),
      .empty(empty));
   htbd_engine u_engine (.clock(clock), .reset(reset), .cmd_valid(!empty),
      .cmd(pop_data), .cmd_pop(pop), .rsp(rsp));
endmodule
`default_nettype wire

@@ tb/sv/tb_scoreboard.sv @@
// Huffman symbol predictor and scoreboard for the tree bit decoder bench.
package tb_scoreboard_pkg;
   import htbd_pkg::*;

   class huff_scoreboard;
      logic [26:0] nodes[MAX_NODES];
      logic [9:0]  stack[STACK_DEPTH];
      int unsigned sp, ncount, walk, qhead, qcount, in_file;
      bit          built;
      logic [31:0] lengths[MAX_FILES];
      logic [15:0] cur_file;
      rsp_type     pending[$];
      int          mismatches;

      function new();
         sp = 0; ncount = 0; walk = 0; qhead = 0; qcount = 0; in_file = 0;
         built = 0; cur_file = 0; mismatches = 0;
      endfunction

      function void push_status(logic [2:0] st);
         rsp_type r;
         r = '0;
         r.out_kind = 1'b1;
         r.file_index = cur_file;
         r.status = st;
         r.last = 1'b1;
         pending.push_back(r);
      endfunction

      function void drop_empty_files();
         while (qcount > 0 && lengths[qhead] == 0) begin
            qhead = (qhead + 1) % MAX_FILES;
            qcount--;
            cur_file++;
         end
      endfunction

      function void add_token(req_type t);
         bit          pend, leaf;
         int unsigned nsp, n, top;
         if (built) begin
            push_status(ST_MISUSE);
            return;
         end
         if (t.node_code != CODE_INTERNAL && t.node_code != CODE_LEAF) begin
            push_status(ST_BAD_CODE);
            return;
         end
         if (ncount >= MAX_NODES) begin
            push_status(ST_MISUSE);
            return;
         end
         leaf = (t.node_code == CODE_LEAF);
         pend = sp > 0 && stack[sp-1][9];
         nsp = sp - (pend ? 1 : 0);
         if (!leaf && nsp >= STACK_DEPTH) begin
            push_status(ST_MISUSE);
            return;
         end
         n = ncount;
         nodes[n] = leaf ? {1'b1, t.leaf_symbol, 18'd0} : 27'd0;
         if (sp > 0) begin
            top = 32'(stack[sp-1][8:0]);
            if (top < MAX_NODES) begin
               if (pend) nodes[top][8:0] = 9'(n);
               else begin
                  nodes[top][17:9] = 9'(n);
                  stack[sp-1][9] = 1'b1;
               end
            end
         end
         sp = nsp;
         ncount++;
         if (!leaf) begin
            stack[sp] = 10'(n);
            sp++;
         end else if (sp == 0) begin
            if (ncount == 1) begin
               ncount = 0;
               push_status(ST_MISUSE);
               return;
            end
            built = 1;
            walk = 0;
         end
      endfunction

      function void decode_byte(logic [7:0] b);
         logic [26:0] e;
         int unsigned nx, cnt;
         rsp_type     r;
         if (!built) begin
            push_status(ST_MISUSE);
            return;
         end
         drop_empty_files();
         cnt = 0;
         for (int i = 7; i >= 0 && qcount > 0; i--) begin
            e = nodes[walk < MAX_NODES ? walk : 0];
            nx = b[i] ? 32'(e[8:0]) : 32'(e[17:9]);
            if (nx >= MAX_NODES) nx = 0;
            e = nodes[nx];
            walk = nx;
            if (e[26]) begin
               in_file++;
               r = '0;
               r.symbol = e[25:18];
               r.file_index = cur_file;
               r.file_end = (in_file == lengths[qhead]);
               pending.push_back(r);
               cnt++;
               walk = 0;
               if (r.file_end) begin
                  in_file = 0;
                  qhead = (qhead + 1) % MAX_FILES;
                  qcount--;
                  cur_file++;
                  drop_empty_files();
               end
            end
         end
         if (qcount == 0) walk = 0;
         if (cnt > 0) pending[pending.size() - 1].last = 1'b1;
      endfunction

      // note an accepted input transaction
      function void note_request(req_type t);
         case (t.kind)
            KIND_TREE: add_token(t);
            KIND_COUNT: begin
               if (qcount >= MAX_FILES) push_status(ST_QFULL);
               else begin
                  lengths[(qhead + qcount) % MAX_FILES] = t.file_length;
                  qcount++;
                  drop_empty_files();
               end
            end
            KIND_DATA: decode_byte(t.data_byte);
            default: begin
               drop_empty_files();
               push_status(qcount > 0 ? ST_INCOMPLETE : ST_OK);
            end
         endcase
      endfunction

      // check an accepted result transaction
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
         end
      endfunction
   endclass
endpackage

@@ tb/sv/tb.sv @@
// Testbench top: drives the huffman tree bit decoder and scores its output.
module tb;
   import htbd_pkg::*;
   import tb_scoreboard_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   htbd_req_if req_ch();
   htbd_rsp_if rsp_ch();
   huff_scoreboard sb;
   int burst_left;

   huffman_tree_bit_decoder uut (.clock(clock), .reset(reset), .req(req_ch.sink),
      .rsp(rsp_ch.source));

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
      end
   end

   // receiver stall pattern: phases of free flow and of random stalls
   initial begin
      int cyc;
      cyc = 0;
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if ((cyc / 300) % 3 == 0) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic send(req_type t);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_ch.data <= t;
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_token(logic [7:0] code, logic [7:0] sym);
      req_type t;
      t = '0;
      t.kind = KIND_TREE;
      t.node_code = code;
      t.leaf_symbol = sym;
      send(t);
   endtask

   task automatic send_count(logic [31:0] len);
      req_type t;
      t = '0;
      t.kind = KIND_COUNT;
      t.file_length = len;
      send(t);
   endtask

   task automatic send_byte(logic [7:0] b);
      req_type t;
      t = '0;
      t.kind = KIND_DATA;
      t.data_byte = b;
      send(t);
   endtask

   task automatic send_eos();
      req_type t;
      t = '0;
      t.kind = KIND_EOS;
      send(t);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // random full tree in preorder with a given number of leaves
   task automatic send_tree(int leaves);
      int split;
      if (leaves <= 1) send_token(CODE_LEAF, 8'($urandom_range(0, 255)));
      else begin
         send_token(CODE_INTERNAL, 8'($urandom_range(0, 255)));
         split = $urandom_range(1, leaves - 1);
         send_tree(split);
         send_tree(leaves - split);
      end
   endtask

   initial begin
      int n;
      sb = new();
      burst_left = 0;
      reset = 1;
      req_ch.valid = 0;
      req_ch.data = '0;
      repeat (8) @(negedge clock);
      reset = 0;

      // directed: misuse before tree, bad code, single leaf, odd symbols
      send_byte(8'hff);
      send_token(8'h00, 8'h00);
      send_token(8'hff, 8'hff);
      send_token(CODE_LEAF, 8'h5a);
      send_eos();
      send_count(32'd0);
      send_count(32'hffff_ffff);
      send_eos();
      send_token(CODE_INTERNAL, 8'h00);
      send_token(CODE_LEAF, 8'h00);
      send_token(CODE_INTERNAL, 8'hff);
      send_token(CODE_LEAF, 8'hff);
      send_token(CODE_LEAF, 8'ha5);
      send_token(CODE_LEAF, 8'h11);
      send_byte(8'h00);
      send_byte(8'hff);
      drain();

      // no reset is applied here; continue with this tree
      reset = 0;
      for (int i = 0; i < 16; i++) send_count($urandom_range(0, 5));
      send_count(32'd3);
      send_eos();
      for (int i = 0; i < 200; i++) begin
         n = $urandom_range(0, 19);
         if (n == 0) send_token(CODE_LEAF, 8'($urandom_range(0, 255)));
         else if (n == 1) send_eos();
         else if (n < 5 && sb.qcount < MAX_FILES) send_count($urandom_range(0, 12));
         else if (n == 5) send_count($urandom);
         else if (sb.qcount == 0) send_count($urandom_range(1, 20));
         else send_byte(8'($urandom_range(0, 255)));
         if (i == 100) drain();
      end
      send_eos();
      drain();

      if (sb.mismatches == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

@@ files.f @@
rtl/htbd_pkg.sv
rtl/htbd_if.sv
rtl/htbd_cmd_fifo.sv
rtl/htbd_engine.sv
rtl/htbd_front.sv
rtl/huffman_tree_bit_decoder.sv
tb/sv/tb_scoreboard.sv
tb/sv/tb.sv
